@@ hw/rtl/pio_pkg.sv @@
// ----------------------------------------------------------------------------
// pio_pkg: shared types and constants of the parallel I/O port registers
// Register map offsets, the register state bundle and the field widths.
// ----------------------------------------------------------------------------
package pio_pkg;

    localparam int unsigned AddrWidth = 7;
    localparam int unsigned DataWidth = 8;
    localparam int unsigned BitSelWidth = 3;

    // Command codes
    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    // Register map
    localparam logic [AddrWidth-1:0] ADDR_PORT_A = 7'h20;
    localparam logic [AddrWidth-1:0] ADDR_PORT_B = 7'h21;
    localparam logic [AddrWidth-1:0] ADDR_DIR_A  = 7'h22;
    localparam logic [AddrWidth-1:0] ADDR_DIR_B  = 7'h23;
    localparam logic [AddrWidth-1:0] ADDR_MODE   = 7'h24;
    localparam logic [AddrWidth-1:0] ADDR_LAST   = 7'h24;

    // Single-bit window: 0x00-0x1F
    localparam int unsigned BitPortSel = 3;   // address bit choosing port B
    localparam int unsigned BitSetSel  = 4;   // address bit choosing set vs clear

    localparam logic [DataWidth-1:0] READ_ALL_ONES = 8'hFF;

    typedef logic [DataWidth-1:0] byte_t;

    typedef struct packed {
        byte_t latch_a;
        byte_t latch_b;
        byte_t direction_a;
        byte_t direction_b;
        byte_t mode;
    } pio_regs_t;

    // Output drive: latch on output pins, high on input pins
    function automatic byte_t drive_of(byte_t latch, byte_t dir);
        return (latch & dir) | ~dir;
    endfunction

endpackage

@@ hw/rtl/pio_decode.sv @@
// ----------------------------------------------------------------------------
// pio_decode: register access decode
// Computes the next register state, the read byte and the bad-address flag
// for one bus request.
// ----------------------------------------------------------------------------
module pio_decode
(
    input  logic                            command,
    input  logic [pio_pkg::AddrWidth-1:0]   address,
    input  pio_pkg::byte_t                  write_data,
    input  pio_pkg::byte_t                  port_a_pins,
    input  pio_pkg::byte_t                  port_b_pins,
    input  pio_pkg::pio_regs_t              regs,
    output pio_pkg::pio_regs_t              regs_next,
    output pio_pkg::byte_t                  read_data,
    output logic                            bad_address
);
    import pio_pkg::*;

    logic                   in_bit_window;
    logic [BitSelWidth-1:0] bit_sel;
    logic                   port_b_sel;
    byte_t                  bit_mask;
    byte_t                  sel_pins;
    byte_t                  sel_latch;
    byte_t                  sel_latch_new;

    assign bad_address   = (address > ADDR_LAST);
    assign in_bit_window = (address < ADDR_PORT_A);
    assign bit_sel       = address[BitSelWidth-1:0];
    assign port_b_sel    = address[BitPortSel];
    assign bit_mask      = byte_t'(1) << bit_sel;
    assign sel_pins      = port_b_sel ? port_b_pins : port_a_pins;
    assign sel_latch     = port_b_sel ? regs.latch_b : regs.latch_a;
    assign sel_latch_new = address[BitSetSel] ? (sel_latch | bit_mask)
                                              : (sel_latch & ~bit_mask);

    always_comb
    begin
        regs_next = regs;
        read_data = '0;
        if (bad_address)
        begin
            read_data = READ_ALL_ONES;
        end
        else if (command == CMD_READ)
        begin
            priority if (address == ADDR_PORT_A)
                read_data = port_a_pins;
            else if (address == ADDR_PORT_B)
                read_data = port_b_pins;
            else if (in_bit_window)
                read_data = {sel_pins[bit_sel], {(DataWidth-1){1'b0}}};
            else
                read_data = READ_ALL_ONES;
        end
        else
        begin
            priority if (address == ADDR_PORT_A)
                regs_next.latch_a = write_data;
            else if (address == ADDR_PORT_B)
                regs_next.latch_b = write_data;
            else if (address == ADDR_DIR_A)
                regs_next.direction_a = write_data;
            else if (address == ADDR_DIR_B)
                regs_next.direction_b = write_data;
            else if (address == ADDR_MODE)
                regs_next.mode = write_data;
            else if (port_b_sel)
                regs_next.latch_b = sel_latch_new;
            else
                regs_next.latch_a = sel_latch_new;
        end
    end

endmodule

@@ hw/rtl/parallel_io_port_registers_core.sv @@
// ----------------------------------------------------------------------------
// parallel_io_port_registers_core: two-port 8-bit parallel I/O register file
// Bus-side register block with output latches, direction and mode registers.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one bus request: command
//   (0 read, 1 write), 7-bit address, write byte and the current levels on
//   the port A and port B pins. Output channel (out_valid/out_ready) returns
//   one result per request: the read byte, both port drive bytes as they
//   stand after the request, and a flag for addresses above 0x24.
//   The result is registered and appears in the cycle after the request is accepted.
//   Throughput: one request per cycle unless stalled; decode is a single
//   pass of logic between the request ports and the result register, and
//   the register state updates in that same edge so the next request sees it.
//   Reset: latches, directions and mode clear (all pins inputs, so both
//   drive bytes read 0xFF once written back), and the result register is
//   emptied.
//   Stall: while a result waits with out_ready low, in_ready drops and the
//   result holds; a request is taken again in the cycle the result leaves.
//   The mode register is stored but the block always runs in basic mode.
// ----------------------------------------------------------------------------
module parallel_io_port_registers_core
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            command,
    input  logic [pio_pkg::AddrWidth-1:0]   address,
    input  pio_pkg::byte_t                  write_data,
    input  pio_pkg::byte_t                  port_a_pins,
    input  pio_pkg::byte_t                  port_b_pins,
    output logic                            out_valid,
    input  logic                            out_ready,
    output pio_pkg::byte_t                  read_data,
    output pio_pkg::byte_t                  port_a_drive,
    output pio_pkg::byte_t                  port_b_drive,
    output logic                            bad_address
);
    import pio_pkg::*;

    pio_regs_t regs_reg;
    pio_regs_t regs_next;
    byte_t     rd_next;
    logic      bad_next;
    logic      accept;

    logic      out_valid_reg;
    byte_t     read_data_reg;
    byte_t     drive_a_reg;
    byte_t     drive_b_reg;
    logic      bad_reg;

    // Take a new request whenever the result slot is empty or draining
    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    pio_decode u_decode
    (
        .command     (command),
        .address     (address),
        .write_data  (write_data),
        .port_a_pins (port_a_pins),
        .port_b_pins (port_b_pins),
        .regs        (regs_reg),
        .regs_next   (regs_next),
        .read_data   (rd_next),
        .bad_address (bad_next)
    );

    // Register state: advance only on an accepted request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg <= '0;
        end
        else if (accept)
        begin
            regs_reg <= regs_next;
        end
    end

    // Result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            out_valid_reg <= in_valid;
        end
    end

    // Result payload: load with the request, hold while stalled
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            read_data_reg <= rd_next;
            drive_a_reg   <= drive_of(regs_next.latch_a, regs_next.direction_a);
            drive_b_reg   <= drive_of(regs_next.latch_b, regs_next.direction_b);
            bad_reg       <= bad_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign read_data    = read_data_reg;
    assign port_a_drive = drive_a_reg;
    assign port_b_drive = drive_b_reg;
    assign bad_address  = bad_reg;

endmodule

@@ hw/rtl/pio_checker.sv @@
// ----------------------------------------------------------------------------
// pio_checker: port-level checks of the parallel I/O register block
// Watches the top level's ports only; attached by the bind below.
// ----------------------------------------------------------------------------
module pio_checker
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          command,
    input logic [pio_pkg::AddrWidth-1:0] address,
    input pio_pkg::byte_t                write_data,
    input pio_pkg::byte_t                port_a_pins,
    input logic                          out_valid,
    input logic                          out_ready,
    input pio_pkg::byte_t                read_data,
    input pio_pkg::byte_t                port_a_drive,
    input pio_pkg::byte_t                port_b_drive,
    input logic                          bad_address
);
    import pio_pkg::*;

    logic in_acc;
    assign in_acc = in_valid && in_ready;

    // Hold a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(read_data)
            && $stable(port_a_drive) && $stable(port_b_drive) && $stable(bad_address))
    else $error("stalled result changed");

    // Each request gets its result in the next cycle, flagged when out of range
    assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> out_valid && (bad_address == ($past(address) > ADDR_LAST)))
    else $error("missing result or wrong bad-address flag");

    // Port A read returns the pins sampled with the request
    assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && command == CMD_READ && address == ADDR_PORT_A
            |=> read_data == $past(port_a_pins))
    else $error("port A read mismatch");

    // Writing an all-input direction drives every port A pin high
    assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && command == CMD_WRITE && address == ADDR_DIR_A && write_data == '0
            |=> port_a_drive == READ_ALL_ONES)
    else $error("input pins not driven high");

endmodule

bind parallel_io_port_registers_core pio_checker u_pio_checker (.*);

@@ bench/tb_parallel_io_port_registers_core.sv @@
// ----------------------------------------------------------------------------
// tb_parallel_io_port_registers_core: self-checking bench of the port registers
// Drives bus requests through a valid/ready channel and checks every result
// against a cycle-free model of the latches, directions and bit addressing.
// ----------------------------------------------------------------------------
module tb_parallel_io_port_registers_core;

    import pio_pkg::*;

    localparam int CLK_PERIOD    = 8;
    localparam int RESET_CYCLES  = 10;
    localparam int RANDOM_COUNT  = 1250;
    localparam int IDLE_PERCENT  = 19;
    localparam int TIMEOUT_TICKS = CLK_PERIOD * 200000;

    // Sender runs without gaps over this stretch of requests.
    localparam int SEND_BUSY_FIRST = 500;
    localparam int SEND_BUSY_LAST  = 750;
    // Receiver never idles over this stretch of cycles ...
    localparam int RECV_BUSY_FIRST = 400;
    localparam int RECV_BUSY_LAST  = 650;
    // ... and holds off once for a long stretch starting here.
    localparam int HOLD_START      = 1000;
    localparam int HOLD_CYCLES     = 60;

    typedef struct packed {
        logic                 command;
        logic [AddrWidth-1:0] address;
        byte_t                write_data;
        byte_t                pins_a;
        byte_t                pins_b;
    } bus_request_t;

    typedef struct packed {
        byte_t read_data;
        byte_t drive_a;
        byte_t drive_b;
        logic  bad_address;
    } port_result_t;

    // ------------------------------------------------------------------------
    // Block signals; the bench-driven inputs are at known values from time zero
    // ------------------------------------------------------------------------
    logic                 clk         = 1'b0;
    logic                 rst_n       = 1'b0;
    logic                 in_valid    = 1'b0;
    logic                 in_ready;
    logic                 command     = CMD_READ;
    logic [AddrWidth-1:0] address     = '0;
    byte_t                write_data  = '0;
    byte_t                port_a_pins = '0;
    byte_t                port_b_pins = '0;
    logic                 out_valid;
    logic                 out_ready   = 1'b0;
    byte_t                read_data;
    byte_t                port_a_drive;
    byte_t                port_b_drive;
    logic                 bad_address;

    // ------------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------------
    bus_request_t pending_requests[$];   // requests not yet offered
    port_result_t expected_results[$];   // results owed by the block, oldest first
    pio_regs_t    shadow_regs = '0;      // model copy of latches, directions, mode
    logic         req_taken   = 1'b0;    // request accepted at the last rising edge
    int           issued_count = 0;
    int           recv_cycle   = 0;
    int           hold_left    = 0;
    int           error_count  = 0;

    parallel_io_port_registers_core DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .command      (command),
        .address      (address),
        .write_data   (write_data),
        .port_a_pins  (port_a_pins),
        .port_b_pins  (port_b_pins),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .read_data    (read_data),
        .port_a_drive (port_a_drive),
        .port_b_drive (port_b_drive),
        .bad_address  (bad_address)
    );

    always
    begin
        #(CLK_PERIOD / 2) clk = 1'b1;
        #(CLK_PERIOD / 2) clk = 1'b0;
    end

    // Print one line per mismatch and count it.
    task automatic report_mismatch(input string msg);
        begin
            $display("MISMATCH @%0t: %s", $time, msg);
            error_count++;
        end
    endtask

    // Build a single-bit window address: set/clear flag, port select, bit index.
    function automatic logic [AddrWidth-1:0] bit_addr(input logic set_bit,
                                                      input logic on_port_b,
                                                      input int unsigned index);
        logic [AddrWidth-1:0] a;
        begin
            a = '0;
            a[BitSelWidth-1:0] = index[BitSelWidth-1:0];
            a[BitPortSel]      = on_port_b;
            a[BitSetSel]       = set_bit;
            return a;
        end
    endfunction

    task automatic queue_request(input logic cmd, input logic [AddrWidth-1:0] addr,
                                 input byte_t data, input byte_t pa, input byte_t pb);
        bus_request_t r;
        begin
            r.command    = cmd;
            r.address    = addr;
            r.write_data = data;
            r.pins_a     = pa;
            r.pins_b     = pb;
            pending_requests.push_back(r);
        end
    endtask

    // ------------------------------------------------------------------------
    // Register file model: apply one request to the shadow state and return
    // the result the block owes for it. Drives reflect the state after it.
    // ------------------------------------------------------------------------
    function automatic port_result_t predict_access(input bus_request_t req);
        port_result_t         res;
        byte_t                pins;
        byte_t                mask;
        logic [AddrWidth-1:0] a;
        begin
            a               = req.address;
            res.read_data   = '0;
            res.bad_address = 1'b0;
            if (a > ADDR_LAST)
            begin
                // Out of the map: ignore the request, flag it, read all ones.
                res.bad_address = 1'b1;
                res.read_data   = READ_ALL_ONES;
            end
            else if (req.command == CMD_READ)
            begin
                if (a == ADDR_PORT_A)
                    res.read_data = req.pins_a;
                else if (a == ADDR_PORT_B)
                    res.read_data = req.pins_b;
                else if (a < ADDR_PORT_A)
                begin
                    // Single-bit read: the chosen pin lands in bit 7.
                    pins          = a[BitPortSel] ? req.pins_b : req.pins_a;
                    res.read_data = {pins[a[BitSelWidth-1:0]], 7'b0};
                end
                else
                    res.read_data = READ_ALL_ONES;   // direction and mode read back ones
            end
            else
            begin
                case (a)
                    ADDR_PORT_A: shadow_regs.latch_a     = req.write_data;
                    ADDR_PORT_B: shadow_regs.latch_b     = req.write_data;
                    ADDR_DIR_A:  shadow_regs.direction_a = req.write_data;
                    ADDR_DIR_B:  shadow_regs.direction_b = req.write_data;
                    ADDR_MODE:   shadow_regs.mode        = req.write_data;
                    default:
                    begin
                        // Single-bit write: write data plays no part.
                        mask = byte_t'(1) << a[BitSelWidth-1:0];
                        if (a[BitPortSel])
                            shadow_regs.latch_b = a[BitSetSel] ?
                                (shadow_regs.latch_b | mask) : (shadow_regs.latch_b & ~mask);
                        else
                            shadow_regs.latch_a = a[BitSetSel] ?
                                (shadow_regs.latch_a | mask) : (shadow_regs.latch_a & ~mask);
                    end
                endcase
            end
            // Output pins follow the latch, input pins float high.
            res.drive_a = (shadow_regs.latch_a & shadow_regs.direction_a)
                          | ~shadow_regs.direction_a;
            res.drive_b = (shadow_regs.latch_b & shadow_regs.direction_b)
                          | ~shadow_regs.direction_b;
            return res;
        end
    endfunction

    // ------------------------------------------------------------------------
    // Driver: advance to the next request at the falling edge once the current
    // one was taken, or idle at random. Hold the payload while valid is high.
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        bus_request_t req;
        logic         no_gap;
        if (rst_n && (!in_valid || req_taken))
        begin
            no_gap = (issued_count >= SEND_BUSY_FIRST) && (issued_count < SEND_BUSY_LAST);
            if (pending_requests.size() != 0 &&
                (no_gap || $urandom_range(99) >= IDLE_PERCENT))
            begin
                req          = pending_requests.pop_front();
                in_valid    <= 1'b1;
                command     <= req.command;
                address     <= req.address;
                write_data  <= req.write_data;
                port_a_pins <= req.pins_a;
                port_b_pins <= req.pins_b;
                issued_count++;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: drop ready at random, keep it high over one stretch, and hold
    // it low over one long stretch so the result register fills and the block
    // stalls its input while the driver keeps offering requests.
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            recv_cycle <= recv_cycle + 1;
            if (hold_left != 0)
            begin
                out_ready <= 1'b0;
                hold_left <= hold_left - 1;
            end
            else if (recv_cycle == HOLD_START)
            begin
                out_ready <= 1'b0;
                hold_left <= HOLD_CYCLES - 1;
            end
            else if (recv_cycle >= RECV_BUSY_FIRST && recv_cycle < RECV_BUSY_LAST)
                out_ready <= 1'b1;
            else
                out_ready <= ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: at the rising edge check any result leaving the block against
    // the oldest expectation, then predict any request entering it.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        port_result_t want;
        bus_request_t req;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                    report_mismatch("result with no request outstanding");
                else
                begin
                    want = expected_results.pop_front();
                    if (read_data !== want.read_data)
                        report_mismatch($sformatf("read_data got %02h want %02h",
                                                  read_data, want.read_data));
                    if (port_a_drive !== want.drive_a)
                        report_mismatch($sformatf("port_a_drive got %02h want %02h",
                                                  port_a_drive, want.drive_a));
                    if (port_b_drive !== want.drive_b)
                        report_mismatch($sformatf("port_b_drive got %02h want %02h",
                                                  port_b_drive, want.drive_b));
                    if (bad_address !== want.bad_address)
                        report_mismatch($sformatf("bad_address got %0b want %0b",
                                                  bad_address, want.bad_address));
                end
            end
            if (in_valid && in_ready)
            begin
                req.command    = command;
                req.address    = address;
                req.write_data = write_data;
                req.pins_a     = port_a_pins;
                req.pins_b     = port_b_pins;
                expected_results.push_back(predict_access(req));
            end
        end
        req_taken <= rst_n && in_valid && in_ready;
    end

    // ------------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------------
    initial
    begin
        int unsigned          pick;
        logic                 cmd;
        logic [AddrWidth-1:0] addr;

        // Directed part: whole-port reads at pin extremes.
        queue_request(CMD_READ,  ADDR_PORT_A, 8'h00, 8'h00, 8'hFF);
        queue_request(CMD_READ,  ADDR_PORT_B, 8'h00, 8'h00, 8'hFF);
        queue_request(CMD_READ,  ADDR_PORT_A, 8'hFF, 8'hFF, 8'h00);
        // Latch written while all pins are inputs: drive stays high.
        queue_request(CMD_WRITE, ADDR_PORT_A, 8'hA5, 8'h00, 8'h00);
        queue_request(CMD_WRITE, ADDR_DIR_A,  8'hFF, 8'h00, 8'h00);
        queue_request(CMD_WRITE, ADDR_DIR_B,  8'h0F, 8'h00, 8'h00);
        queue_request(CMD_WRITE, ADDR_PORT_B, 8'h3C, 8'h00, 8'h00);
        queue_request(CMD_WRITE, ADDR_MODE,   8'hFF, 8'h00, 8'h00);
        // Direction and mode read back as all ones.
        queue_request(CMD_READ,  ADDR_DIR_A,  8'h00, 8'h12, 8'h34);
        queue_request(CMD_READ,  ADDR_DIR_B,  8'h00, 8'h12, 8'h34);
        queue_request(CMD_READ,  ADDR_MODE,   8'h00, 8'h12, 8'h34);
        // Single-bit set and clear on both ports, write data ignored.
        queue_request(CMD_WRITE, bit_addr(1'b1, 1'b0, 0), 8'h00, 8'h00, 8'h00);
        queue_request(CMD_WRITE, bit_addr(1'b1, 1'b1, 7), 8'h00, 8'h00, 8'h00);
        queue_request(CMD_WRITE, bit_addr(1'b0, 1'b0, 7), 8'hFF, 8'h00, 8'h00);
        queue_request(CMD_WRITE, bit_addr(1'b0, 1'b1, 0), 8'hFF, 8'h00, 8'h00);
        // Single-bit reads: pin lands in bit 7, set flag has no effect on reads.
        queue_request(CMD_READ,  bit_addr(1'b0, 1'b0, 0), 8'h00, 8'h01, 8'hFE);
        queue_request(CMD_READ,  bit_addr(1'b0, 1'b1, 7), 8'h00, 8'h7F, 8'h80);
        queue_request(CMD_READ,  bit_addr(1'b1, 1'b0, 3), 8'h00, 8'hF7, 8'hFF);
        queue_request(CMD_READ,  bit_addr(1'b1, 1'b1, 5), 8'h00, 8'h00, 8'h20);
        // Addresses past the map, read and write.
        queue_request(CMD_READ,  ADDR_LAST + 7'd1, 8'h00, 8'hAA, 8'h55);
        queue_request(CMD_WRITE, 7'h7F,            8'h55, 8'h00, 8'h00);
        queue_request(CMD_READ,  7'h7F,            8'hFF, 8'hFF, 8'hFF);
        // Flip the directions back the other way.
        queue_request(CMD_WRITE, ADDR_DIR_A,  8'h00, 8'h00, 8'h00);
        queue_request(CMD_WRITE, ADDR_DIR_B,  8'hFF, 8'h00, 8'h00);
        queue_request(CMD_WRITE, ADDR_MODE,   8'h00, 8'h00, 8'h00);

        // Random part: weight toward the mapped registers and bit window.
        for (int i = 0; i < RANDOM_COUNT; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 35)
                addr = AddrWidth'($urandom_range(0, int'(ADDR_PORT_A) - 1));
            else if (pick < 75)
                addr = AddrWidth'($urandom_range(int'(ADDR_PORT_A), int'(ADDR_LAST)));
            else if (pick < 88)
                addr = AddrWidth'($urandom_range(int'(ADDR_LAST) + 1, 127));
            else
                addr = AddrWidth'($urandom_range(0, 127));
            cmd = $urandom_range(1) ? CMD_WRITE : CMD_READ;
            queue_request(cmd, addr, byte_t'($urandom), byte_t'($urandom), byte_t'($urandom));
        end

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        // Drain: every request offered and taken, every result checked.
        while (pending_requests.size() != 0 || in_valid || expected_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);

        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #(TIMEOUT_TICKS);
        $display("Test completed with failures");
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/pio_pkg.sv
hw/rtl/pio_decode.sv
hw/rtl/parallel_io_port_registers_core.sv
hw/rtl/pio_checker.sv
bench/tb_parallel_io_port_registers_core.sv
